### src/psg_pkg.sv
// Package for the four-voice tone and noise generator.
// Holds operation and register codes, the volume table and the noise mask builder.
// No dependencies.
`default_nettype none

package psg_pkg;

    typedef enum logic [1:0] {
        OP_SOUND  = 2'd0,
        OP_STEREO = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_NOISE_PATTERN = 2'd0,
        CFG_NOISE_WIDTH   = 2'd1,
        CFG_CHAN_ENABLE   = 2'd2,
        CFG_CHAN_MUTE     = 2'd3
    } cfg_idx_t;

    localparam int unsigned NUM_TONES  = 3;
    localparam logic [1:0]  NOISE_VOICE = 2'd3;

    localparam logic [9:0]  STEADY_TONE_MAX  = 10'd5;
    localparam logic [15:0] NOISE_RELOAD     = 16'h8000;
    localparam logic [15:0] NOISE_TAPS_RESET = 16'h9000;
    localparam logic [15:0] DEFAULT_PATTERN  = 16'h0003;
    localparam logic [4:0]  DEFAULT_WIDTH    = 5'd15;
    localparam logic [4:0]  MAX_WIDTH        = 5'd16;
    localparam logic [3:0]  ATT_SILENT       = 4'd15;
    localparam logic [7:0]  STEREO_RESET     = 8'hFF;

    localparam logic [10:0] NOISE_TICKS_0 = 11'((16'h100 * 2) / 16);
    localparam logic [10:0] NOISE_TICKS_1 = 11'((16'h200 * 2) / 16);
    localparam logic [10:0] NOISE_TICKS_2 = 11'((16'h400 * 2) / 16);

    function automatic logic [7:0] vol_lookup(input logic [3:0] att);
        logic [7:0] v;
        case (att)
            4'd0:    v = 8'd128;
            4'd1:    v = 8'd102;
            4'd2:    v = 8'd81;
            4'd3:    v = 8'd64;
            4'd4:    v = 8'd51;
            4'd5:    v = 8'd40;
            4'd6:    v = 8'd32;
            4'd7:    v = 8'd26;
            4'd8:    v = 8'd20;
            4'd9:    v = 8'd16;
            4'd10:   v = 8'd13;
            4'd11:   v = 8'd10;
            4'd12:   v = 8'd8;
            4'd13:   v = 8'd6;
            4'd14:   v = 8'd5;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] noise_mask(input logic [15:0] pattern,
                                               input logic [4:0]  width,
                                               input logic        white);
        logic [15:0] pat;
        logic [4:0]  w;
        logic [15:0] m;
        pat = pattern;
        w   = width;
        m   = '0;
        if (pat == '0 || w == '0) begin
            pat = DEFAULT_PATTERN;
            w   = DEFAULT_WIDTH;
        end
        if (w > MAX_WIDTH) begin
            w = MAX_WIDTH;
        end
        if (!white) begin
            m[4'(w - 5'd1)] = 1'b1;
        end else begin
            for (int j = 0; j < 16; j++) begin
                if (5'(j) < w) begin
                    m[j] = pat[4'(w - 5'd1 - 5'(j))];
                end
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### src/psg_tone_noise_generator.sv
// Top level of the four-voice tone and noise generator.
// Uses psg_pkg for codes, the volume table and the noise mask builder.
//
// Usage:
//   Input stream: s_tdata carries a register byte, s_tuser the operation
//   (sound register byte, stereo routing byte, or one tick).
//   Every accepted request yields exactly one result on the m_ stream: the
//   three tone levels, the noise level and the left and right mixes, taken
//   after the request has updated the voice state.
//   Latency: the result is valid the cycle after the request is accepted.
//   Throughput: one request per cycle unless stalled; the state update and the
//   level/mix logic sit between the voice registers and the output register.
//   Stall: while the output register holds a result that is not taken,
//   s_tready drops; it rises again in the cycle the result is taken, so a
//   new request and the hand-off of the old result can share a cycle.
//   Reset: aresetn (synchronous, active low) silences all voices, reloads
//   the noise shifter, routes every voice to both sides and restores the
//   configuration defaults. Configuration writes go through cfg_wr_en,
//   cfg_addr and cfg_wdata and take effect at the next clock edge.
`default_nettype none

module psg_tone_noise_generator
    import psg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data
    input  wire logic [1:0]  s_tuser,   // [1:0] operation

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [8:0] tone0_level, [17:9] tone1_level, [26:18] tone2_level,
    // [34:27] noise_level, [44:35] left_mix, [54:45] right_mix, [55] zero
    output logic [55:0]      m_tdata
);

    logic [15:0] noise_pattern_reg;
    logic [4:0]  noise_width_reg;
    logic [3:0]  chan_enable_reg;
    logic [3:0]  chan_mute_reg;

    logic [2:0]  latched_select_reg, latched_select_next;
    logic [9:0]  tone_period_reg  [NUM_TONES];
    logic [9:0]  tone_period_next [NUM_TONES];
    logic [9:0]  tone_counter_reg [NUM_TONES];
    logic [9:0]  tone_counter_next[NUM_TONES];
    logic [2:0]  tone_phase_reg, tone_phase_next;
    logic [3:0]  attenuation_reg  [4];
    logic [3:0]  attenuation_next [4];
    logic [1:0]  noise_rate_reg, noise_rate_next;
    logic [15:0] noise_taps_reg, noise_taps_next;
    logic [15:0] noise_shifter_reg, noise_shifter_next;
    logic [10:0] noise_counter_reg, noise_counter_next;
    logic [7:0]  stereo_reg, stereo_next;

    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg, m_tdata_next;

    logic        s_fire;
    op_t         op;
    logic [1:0]  voice_idx;
    logic [3:0]  voice_runs;
    logic        noise_write;
    logic [10:0] noise_period;

    logic [8:0]  tone_level [NUM_TONES];
    logic [7:0]  noise_level;
    logic [7:0]  vol;
    logic [9:0]  left_mix, right_mix;

    assign s_tready   = !m_tvalid_reg || m_tready;
    assign s_fire     = s_tvalid && s_tready;
    assign op         = op_t'(s_tuser);
    assign voice_runs = chan_enable_reg & ~chan_mute_reg;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    always_comb begin
        case (noise_rate_reg)
            2'd0:    noise_period = NOISE_TICKS_0;
            2'd1:    noise_period = NOISE_TICKS_1;
            2'd2:    noise_period = NOISE_TICKS_2;
            default: noise_period = {tone_period_reg[2], 1'b0};
        endcase
        if (noise_period == '0) begin
            noise_period = 11'd1;
        end
    end

    // State update for one request
    always_comb begin
        latched_select_next = latched_select_reg;
        tone_period_next    = tone_period_reg;
        tone_counter_next   = tone_counter_reg;
        tone_phase_next     = tone_phase_reg;
        attenuation_next    = attenuation_reg;
        noise_rate_next     = noise_rate_reg;
        noise_taps_next     = noise_taps_reg;
        noise_shifter_next  = noise_shifter_reg;
        noise_counter_next  = noise_counter_reg;
        stereo_next         = stereo_reg;
        noise_write         = 1'b0;
        voice_idx           = '0;

        case (op)
            OP_SOUND: begin
                if (s_tdata[7]) begin
                    latched_select_next = s_tdata[6:4];
                end
                voice_idx = latched_select_next[2:1];
                if (chan_enable_reg[voice_idx]) begin
                    if (latched_select_next[0]) begin
                        attenuation_next[voice_idx] = s_tdata[3:0];
                    end else if (voice_idx != NOISE_VOICE) begin
                        for (int v = 0; v < NUM_TONES; v++) begin
                            if (voice_idx == 2'(v)) begin
                                if (s_tdata[7]) begin
                                    tone_period_next[v] = {tone_period_reg[v][9:4],
                                                           s_tdata[3:0]};
                                end else begin
                                    tone_period_next[v] = {s_tdata[5:0],
                                                           tone_period_reg[v][3:0]};
                                end
                            end
                        end
                    end else begin
                        noise_write        = 1'b1;
                        noise_rate_next    = s_tdata[1:0];
                        noise_taps_next    = noise_mask(noise_pattern_reg, noise_width_reg,
                                                        s_tdata[2]);
                        noise_shifter_next = NOISE_RELOAD;
                    end
                end
            end
            OP_STEREO: begin
                stereo_next = s_tdata;
            end
            OP_TICK: begin
                for (int v = 0; v < NUM_TONES; v++) begin
                    if (voice_runs[v]) begin
                        if (tone_period_reg[v] == '0) begin
                            tone_counter_next[v] = '0;
                        end else if (tone_counter_reg[v] == '0) begin
                            tone_phase_next[v]   = ~tone_phase_reg[v];
                            tone_counter_next[v] = tone_period_reg[v] - 10'd1;
                        end else begin
                            tone_counter_next[v] = tone_counter_reg[v] - 10'd1;
                        end
                    end
                end
                if (voice_runs[3]) begin
                    if (attenuation_reg[3] == ATT_SILENT) begin
                        noise_counter_next = '0;
                    end else if (noise_counter_reg == '0) begin
                        noise_shifter_next = (noise_shifter_reg[0] ? noise_taps_reg : 16'd0)
                                             ^ (noise_shifter_reg >> 1);
                        noise_counter_next = noise_period - 11'd1;
                    end else begin
                        noise_counter_next = noise_counter_reg - 11'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Levels and mixes of the updated state
    always_comb begin
        left_mix  = '0;
        right_mix = '0;
        vol       = '0;
        for (int v = 0; v < NUM_TONES; v++) begin
            vol = vol_lookup(attenuation_next[v]);
            if (tone_period_next[v] > STEADY_TONE_MAX) begin
                tone_level[v] = tone_phase_next[v] ? {vol, 1'b0} : 9'd0;
            end else begin
                tone_level[v] = {1'b0, vol};
            end
            if (!voice_runs[v]) begin
                tone_level[v] = '0;
            end
            if (stereo_next[v]) begin
                right_mix = right_mix + 10'(tone_level[v]);
            end
            if (stereo_next[v + 4]) begin
                left_mix = left_mix + 10'(tone_level[v]);
            end
        end
        noise_level = (voice_runs[3] && !noise_shifter_next[0])
                      ? vol_lookup(attenuation_next[3]) : 8'd0;
        if (stereo_next[3]) begin
            right_mix = right_mix + 10'(noise_level);
        end
        if (stereo_next[7]) begin
            left_mix = left_mix + 10'(noise_level);
        end
        m_tdata_next = {1'b0, right_mix, left_mix, noise_level,
                        tone_level[2], tone_level[1], tone_level[0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_pattern_reg <= DEFAULT_PATTERN;
            noise_width_reg   <= DEFAULT_WIDTH;
            chan_enable_reg   <= 4'hF;
            chan_mute_reg     <= 4'h0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_NOISE_PATTERN: noise_pattern_reg <= cfg_wdata;
                CFG_NOISE_WIDTH:   noise_width_reg   <= cfg_wdata[4:0];
                CFG_CHAN_ENABLE:   chan_enable_reg   <= cfg_wdata[3:0];
                CFG_CHAN_MUTE:     chan_mute_reg     <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latched_select_reg <= '0;
            for (int v = 0; v < NUM_TONES; v++) begin
                tone_period_reg[v]  <= '0;
                tone_counter_reg[v] <= '0;
            end
            tone_phase_reg <= '0;
            for (int v = 0; v < 4; v++) begin
                attenuation_reg[v] <= ATT_SILENT;
            end
            noise_rate_reg    <= '0;
            noise_taps_reg    <= NOISE_TAPS_RESET;
            noise_shifter_reg <= NOISE_RELOAD;
            noise_counter_reg <= '0;
            stereo_reg        <= STEREO_RESET;
        end else if (s_fire) begin
            latched_select_reg <= latched_select_next;
            tone_period_reg    <= tone_period_next;
            tone_counter_reg   <= tone_counter_next;
            tone_phase_reg     <= tone_phase_next;
            attenuation_reg    <= attenuation_next;
            noise_rate_reg     <= noise_rate_next;
            noise_taps_reg     <= noise_taps_next;
            noise_shifter_reg  <= noise_shifter_next;
            noise_counter_reg  <= noise_counter_next;
            stereo_reg         <= stereo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid_reg)
        else $error("output valid after reset");

    a_request_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_tvalid_reg)
        else $error("accepted request produced no result");

    a_stereo_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && op == OP_STEREO |=> stereo_reg == $past(s_tdata))
        else $error("stereo routing byte not taken");

    a_noise_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && noise_write |=> noise_shifter_reg == NOISE_RELOAD)
        else $error("noise shifter not reloaded on control write");

    a_disabled_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !chan_enable_reg[0] |=> m_tdata_reg[8:0] == 9'd0)
        else $error("disabled tone voice 0 not silent");

endmodule

`default_nettype wire
